FILE: rtl/epos_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epos_pkg
// Shared types and constants for the elevation bang-bang positioner.
// ----------------------------------------------------------------------------
package epos_pkg;

    localparam int ANGLE_MAX_DEF     = 9000;
    localparam int SIM_TOLERANCE_DEF = 5;

    localparam int BAND_W   = 14;
    localparam int TIME_W   = 32;
    localparam int TGT_IN_W = 17;
    localparam int MEAS_W   = 16;
    localparam int CALC_W   = 18;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;

    localparam logic [BAND_W-1:0] BRAKE_BAND_RST = BAND_W'(100);
    localparam logic [TIME_W-1:0] TIMEOUT_RST    = TIME_W'(60000);

    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_BAND = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SIM_MODE   = CFG_IDX_W'(2);

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef struct packed {
        logic                       opcode;
        logic signed [TGT_IN_W-1:0] target_angle;
        logic signed [MEAS_W-1:0]   measured_angle;
        logic [TIME_W-1:0]          now_ms;
    } t_item;

    typedef struct packed {
        logic                     drive_enable;
        logic                     drive_up;
        logic                     busy;
        logic                     timed_out;
        logic signed [MEAS_W-1:0] parked_angle;
    } t_result;

endpackage
`default_nettype wire

FILE: rtl/elevation_bang_bang_positioner_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// An item waits in the input register until the result register is free
// or being read (one input register, one result register).
// Throughput: one item per cycle unless i_out_ready stalls the result; the move
// decision is one stage of compares and subtracts between the two registers.
// Reset (synchronous, active low) empties both registers, clears the move
// state and loads brake_band 100, timeout_ms 60000, sim_mode 0.
// ----------------------------------------------------------------------------
// elevation_bang_bang_positioner_unit
// Elevation on/off positioner with brake band and move timeout.
// ----------------------------------------------------------------------------
module elevation_bang_bang_positioner_unit
    import epos_pkg::*;
#(
    parameter int ANGLE_MAX     = ANGLE_MAX_DEF,
    parameter int SIM_TOLERANCE = SIM_TOLERANCE_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0]       i_cfg_data,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic                       i_opcode,
    input  wire logic signed [TGT_IN_W-1:0] i_target_angle,
    input  wire logic signed [MEAS_W-1:0]   i_measured_angle,
    input  wire logic [TIME_W-1:0]          i_now_ms,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic                            o_drive_enable,
    output logic                            o_drive_up,
    output logic                            o_busy_res,
    output logic                            o_timed_out,
    output logic signed [MEAS_W-1:0]        o_parked_angle
);

    logic [BAND_W-1:0] r_band;
    logic [TIME_W-1:0] r_timeout;
    logic              r_sim_mode;

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_out;
    t_result core_res;
    logic    adv;

    assign o_cfg_ready  = 1'b1;
    assign adv          = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready   = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band     <= BRAKE_BAND_RST;
            r_timeout  <= TIMEOUT_RST;
            r_sim_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BRAKE_BAND: r_band     <= i_cfg_data[BAND_W-1:0];
                CFG_TIMEOUT:    r_timeout  <= i_cfg_data[TIME_W-1:0];
                CFG_SIM_MODE:   r_sim_mode <= i_cfg_data[0];
                default:        r_sim_mode <= r_sim_mode;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item.opcode         <= i_opcode;
            r_item.target_angle   <= i_target_angle;
            r_item.measured_angle <= i_measured_angle;
            r_item.now_ms         <= i_now_ms;
        end
    end

    epos_core #(
        .ANGLE_MAX     (ANGLE_MAX),
        .SIM_TOLERANCE (SIM_TOLERANCE)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (adv),
        .i_item       (r_item),
        .i_brake_band (r_band),
        .i_timeout_ms (r_timeout),
        .i_sim_mode   (r_sim_mode),
        .o_res        (core_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_drive_enable = r_out.drive_enable;
    assign o_drive_up     = r_out.drive_up;
    assign o_busy_res     = r_out.busy;
    assign o_timed_out    = r_out.timed_out;
    assign o_parked_angle = r_out.parked_angle;

    a_timeout_ends_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.timed_out |-> !r_out.busy && !r_out.drive_enable)
        else $error("timeout result still shows an active move");

    a_reset_empties_out: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !r_out_valid && !r_in_valid)
        else $error("pipeline not empty after reset");

    a_in_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid)
        else $error("pending item dropped while stalled");

    a_out_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid)
        else $error("result dropped while stalled");

endmodule
`default_nettype wire

FILE: rtl/epos_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// epos_core
// Move state and the start / tick decision logic for one item.
// ----------------------------------------------------------------------------
module epos_core
    import epos_pkg::*;
#(
    parameter int ANGLE_MAX     = ANGLE_MAX_DEF,
    parameter int SIM_TOLERANCE = SIM_TOLERANCE_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire t_item             i_item,
    input  wire logic [BAND_W-1:0] i_brake_band,
    input  wire logic [TIME_W-1:0] i_timeout_ms,
    input  wire logic              i_sim_mode,
    output t_result                o_res
);

    localparam int TGT_W = $clog2(ANGLE_MAX + 1);
    localparam logic signed [CALC_W-1:0] ANGLE_MAX_C = CALC_W'(ANGLE_MAX);
    localparam logic signed [CALC_W-1:0] SIM_TOL_C   = CALC_W'(SIM_TOLERANCE);

    logic                     r_moving, n_moving;
    logic                     r_going_up, n_going_up;
    logic                     r_drive_on, n_drive_on;
    logic [TGT_W-1:0]         r_target, n_target;
    logic [TIME_W-1:0]        r_start_time, n_start_time;
    logic signed [MEAS_W-1:0] r_parked, n_parked;
    logic                     timed_out;

    logic signed [CALC_W-1:0] tgt_ext, tgt_clamp, meas_ext, diff, diff_abs;
    logic signed [CALC_W-1:0] band_ext, tgt_reg_ext;
    logic [TIME_W-1:0]        elapsed;
    logic                     stop;

    always_comb begin
        tgt_ext  = CALC_W'(i_item.target_angle);
        meas_ext = CALC_W'(i_item.measured_angle);
        band_ext = signed'({{(CALC_W-BAND_W){1'b0}}, i_brake_band});
        tgt_reg_ext = signed'({{(CALC_W-TGT_W){1'b0}}, r_target});

        if (tgt_ext < 0) begin
            tgt_clamp = '0;
        end else if (tgt_ext > ANGLE_MAX_C) begin
            tgt_clamp = ANGLE_MAX_C;
        end else begin
            tgt_clamp = tgt_ext;
        end

        diff     = meas_ext - tgt_clamp;
        diff_abs = (diff < 0) ? -diff : diff;
        elapsed  = i_item.now_ms - r_start_time;

        if (r_going_up) begin
            stop = meas_ext >= (tgt_reg_ext - band_ext);
        end else begin
            stop = meas_ext <= (tgt_reg_ext + band_ext);
        end

        n_moving     = r_moving;
        n_going_up   = r_going_up;
        n_drive_on   = r_drive_on;
        n_target     = r_target;
        n_start_time = r_start_time;
        n_parked     = r_parked;
        timed_out    = 1'b0;

        if (i_item.opcode == OP_START) begin
            n_target = tgt_clamp[TGT_W-1:0];
            if (i_sim_mode) begin
                if (diff_abs <= SIM_TOL_C) begin
                    n_parked = tgt_clamp[MEAS_W-1:0];
                    n_moving = 1'b0;
                end else begin
                    n_moving = 1'b1;
                end
            end else begin
                n_start_time = i_item.now_ms;
                n_drive_on   = 1'b0;
                if (diff_abs <= band_ext) begin
                    n_parked = i_item.measured_angle;
                    n_moving = 1'b0;
                end else begin
                    n_going_up = meas_ext < tgt_clamp;
                    n_drive_on = 1'b1;
                    n_moving   = 1'b1;
                end
            end
        end else if (r_moving && !i_sim_mode) begin
            if (elapsed > i_timeout_ms) begin
                n_drive_on = 1'b0;
                n_moving   = 1'b0;
                timed_out  = 1'b1;
            end else if (stop) begin
                n_drive_on = 1'b0;
                n_parked   = i_item.measured_angle;
                n_moving   = 1'b0;
            end
        end

        o_res.drive_enable = n_drive_on;
        o_res.drive_up     = n_going_up;
        o_res.busy         = n_moving;
        o_res.timed_out    = timed_out;
        o_res.parked_angle = n_parked;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_moving     <= 1'b0;
            r_going_up   <= 1'b0;
            r_drive_on   <= 1'b0;
            r_target     <= '0;
            r_start_time <= '0;
            r_parked     <= '0;
        end else if (i_en) begin
            r_moving     <= n_moving;
            r_going_up   <= n_going_up;
            r_drive_on   <= n_drive_on;
            r_target     <= n_target;
            r_start_time <= n_start_time;
            r_parked     <= n_parked;
        end
    end

endmodule
`default_nettype wire
